// File: design/vphc_pkg.sv
// Shared types, constants and a helper function of the vacuum pressure controller.
package vphc_pkg;

	localparam int ADC_IN_W        = 10;
	localparam int AVG_SAMPLES_DEF = 64;
	localparam int ADC_BITS_DEF    = 10;

	localparam int P_W   = 11;
	localparam int SP_W  = 10;
	localparam int HY_W  = 7;
	localparam int CNT_W = 4;
	localparam int CMP_W = 12;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_HYSTERESIS  = 3'd0;
	localparam logic [2:0] REG_CEILING     = 3'd1;
	localparam logic [2:0] REG_PRESET      = 3'd2;
	localparam logic [2:0] REG_PUMP_CUTOFF = 3'd3;
	localparam logic [2:0] REG_OFFSET      = 3'd4;
	localparam logic [2:0] REG_FAST_AFTER  = 3'd5;

	localparam logic [HY_W-1:0]  HYSTERESIS_RST = 7'd10;
	localparam logic [SP_W-1:0]  CEILING_RST    = 10'd800;
	localparam logic [SP_W-1:0]  PRESET_RST     = 10'd740;
	localparam logic [SP_W-1:0]  CUTOFF_RST     = 10'd730;
	localparam logic [SP_W-1:0]  OFFSET_RST     = 10'd200;
	localparam logic [CNT_W-1:0] FAST_AFTER_RST = 4'd13;
	localparam logic [SP_W-1:0]  SETPOINT_RST   = 10'd740;

	// Pressure = (diff * 147) / 100, the division done as a reciprocal multiply.
	localparam int D147_W    = 18;
	localparam int SCALE_NUM = 147;
	localparam int DIV100_W  = 19;
	localparam int DIV100_M  = 335545;
	localparam int DIV100_SH = 25;
	localparam int Q_W       = D147_W + DIV100_W;

	// Digit extraction of values below 1000 and below 100.
	localparam int HUND_M  = 41;
	localparam int HUND_SH = 12;
	localparam int TENS_M  = 103;
	localparam int TENS_SH = 10;

	typedef struct packed {
		logic [HY_W-1:0]  hysteresis;
		logic [SP_W-1:0]  setpoint_ceiling;
		logic [SP_W-1:0]  preset_setpoint;
		logic [SP_W-1:0]  pump_cutoff;
		logic [SP_W-1:0]  sensor_offset;
		logic [CNT_W-1:0] fast_repeat_after;
	} cfg_t;

	typedef struct packed {
		logic raise;
		logic lower;
		logic zero;
		logic vent;
	} btn_t;

	typedef struct packed {
		logic           valid;
		logic [Q_W-1:0] q;
		btn_t           btn;
	} avg_res_t;

	typedef struct packed {
		logic           valid;
		logic           pump;
		logic           valve;
		logic           setting;
		logic           fast;
		logic [P_W-1:0] p;
		logic [P_W-1:0] disp;
	} ctrl_res_t;

	typedef struct packed {
		logic           valid;
		logic           pump;
		logic           valve;
		logic           setting;
		logic           fast;
		logic [P_W-1:0] p;
		logic [7:0]     seg_units;
		logic [7:0]     seg_tens;
		logic [7:0]     seg_hundreds;
		logic [7:0]     seg_thousands;
	} disp_res_t;

	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] s;
		case (digit)
			4'd0: s = 8'hfa;
			4'd1: s = 8'h82;
			4'd2: s = 8'hb9;
			4'd3: s = 8'hab;
			4'd4: s = 8'hc3;
			4'd5: s = 8'h6b;
			4'd6: s = 8'h7b;
			4'd7: s = 8'ha2;
			4'd8: s = 8'hfb;
			4'd9: s = 8'heb;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: design/vphc_in_if.sv
// Input channel: one ADC sample and four button levels per transfer.
interface vphc_in_if import vphc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADC_IN_W-1:0] adc_sample;
	logic                btn_raise;
	logic                btn_lower;
	logic                btn_zero;
	logic                btn_vent;

	modport source(output valid, adc_sample, btn_raise, btn_lower, btn_zero, btn_vent,
		input ready);
	modport sink(input valid, adc_sample, btn_raise, btn_lower, btn_zero, btn_vent,
		output ready);
endinterface

// File: design/vphc_out_if.sv
// Output channel: drive states, flags, pressure and display segments per transfer.
interface vphc_out_if import vphc_pkg::*; ();
	logic           valid;
	logic           ready;
	logic           pump_on;
	logic           valve_open;
	logic           setting_active;
	logic           fast_repeat;
	logic [P_W-1:0] pressure_torr;
	logic [7:0]     seg_units;
	logic [7:0]     seg_tens;
	logic [7:0]     seg_hundreds;
	logic [7:0]     seg_thousands;

	modport source(output valid, pump_on, valve_open, setting_active, fast_repeat,
		pressure_torr, seg_units, seg_tens, seg_hundreds, seg_thousands, input ready);
	modport sink(input valid, pump_on, valve_open, setting_active, fast_repeat,
		pressure_torr, seg_units, seg_tens, seg_hundreds, seg_thousands, output ready);
endinterface

// File: design/vphc_cfg.sv
// APB configuration register file.
module vphc_cfg import vphc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis        <= HYSTERESIS_RST;
			cfg_q.setpoint_ceiling  <= CEILING_RST;
			cfg_q.preset_setpoint   <= PRESET_RST;
			cfg_q.pump_cutoff       <= CUTOFF_RST;
			cfg_q.sensor_offset     <= OFFSET_RST;
			cfg_q.fast_repeat_after <= FAST_AFTER_RST;
		end else if (wr) begin
			case (idx)
				REG_HYSTERESIS:  cfg_q.hysteresis        <= pwdata[HY_W-1:0];
				REG_CEILING:     cfg_q.setpoint_ceiling  <= pwdata[SP_W-1:0];
				REG_PRESET:      cfg_q.preset_setpoint   <= pwdata[SP_W-1:0];
				REG_PUMP_CUTOFF: cfg_q.pump_cutoff       <= pwdata[SP_W-1:0];
				REG_OFFSET:      cfg_q.sensor_offset     <= pwdata[SP_W-1:0];
				REG_FAST_AFTER:  cfg_q.fast_repeat_after <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HYSTERESIS:  prdata = PDATA_W'(cfg_q.hysteresis);
			REG_CEILING:     prdata = PDATA_W'(cfg_q.setpoint_ceiling);
			REG_PRESET:      prdata = PDATA_W'(cfg_q.preset_setpoint);
			REG_PUMP_CUTOFF: prdata = PDATA_W'(cfg_q.pump_cutoff);
			REG_OFFSET:      prdata = PDATA_W'(cfg_q.sensor_offset);
			REG_FAST_AFTER:  prdata = PDATA_W'(cfg_q.fast_repeat_after);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: design/vphc_avg.sv
// Sample accumulation, averaging and scaling to a pressure product.
module vphc_avg import vphc_pkg::*; #(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF,
	parameter int ADC_BITS    = ADC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_acc,
	input  logic [ADC_IN_W-1:0] adc_sample,
	input  btn_t                btn,
	input  logic [SP_W-1:0]     sensor_offset,
	output avg_res_t            res
);

	localparam int SB       = (ADC_BITS < ADC_IN_W) ? ADC_BITS : ADC_IN_W;
	localparam int AVG_LOG  = $clog2(AVG_SAMPLES);
	localparam int SUM_W    = SB + AVG_LOG;
	localparam int IDX_W    = (AVG_LOG > 0) ? AVG_LOG : 1;
	localparam int RECIP_SH = SUM_W + 7;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / AVG_SAMPLES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_SAMPLES - 1);

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SB-1:0]       sample_s1;
	btn_t                btn_s1, btn_s2, btn_s3, btn_s4, btn_s5;
	logic [SUM_W-1:0]    sum_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SUM_W-1:0]    total_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic [D147_W-1:0]   d147_s4;
	logic [Q_W-1:0]      q_s5;
	logic [SUM_W-1:0]    total;
	logic [SP_W-1:0]     avg;
	logic [SP_W-1:0]     diff;

	assign total = sum_q + SUM_W'(sample_s1);
	assign avg   = SP_W'(prod_s3[RECIP_SH +: SB]);
	assign diff  = (avg >= sensor_offset) ? (avg - sensor_offset) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			sum_q <= '0;
			idx_q <= '0;
		end else if (adv) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1 && (idx_q == LAST_IDX);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s1) begin
				if (idx_q == LAST_IDX) begin
					sum_q <= '0;
					idx_q <= '0;
				end else begin
					sum_q <= total;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= adc_sample[SB-1:0];
			btn_s1    <= btn;
			total_s2  <= total;
			btn_s2    <= btn_s1;
			prod_s3   <= PROD_W'(total_s2) * PROD_W'(RECIP);
			btn_s3    <= btn_s2;
			d147_s4   <= D147_W'(diff) * D147_W'(SCALE_NUM);
			btn_s4    <= btn_s3;
			q_s5      <= Q_W'(d147_s4) * Q_W'(DIV100_M);
			btn_s5    <= btn_s4;
		end
	end

	assign res.valid = v_s5;
	assign res.q     = q_s5;
	assign res.btn   = btn_s5;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("sample index beyond the averaging window");

	a_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1) && $past(adv))
		else $error("group sum appeared without a sample transfer");

endmodule

// File: design/vphc_ctrl.sv
// Pump and valve hysteresis control and setpoint button handling.
module vphc_ctrl import vphc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  avg_res_t  res,
	input  cfg_t      cfg,
	output ctrl_res_t ctl
);

	logic [SP_W-1:0]  setpoint_q;
	logic             setting_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pump_q;
	logic             valve_q;
	ctrl_res_t        ctl_s6;

	logic [CMP_W-1:0] p_full;
	logic [P_W-1:0]   p;
	logic [CMP_W-1:0] p12, sp12, hy12;
	logic             pump_n, valve_n, setting_n;
	logic [SP_W-1:0]  sp_n;
	logic [CNT_W-1:0] cnt_n;

	always_comb begin
		p_full = res.q[DIV100_SH +: CMP_W];
		p      = p_full[CMP_W-1] ? '1 : p_full[P_W-1:0];
		p12    = CMP_W'(p);
		sp12   = CMP_W'(setpoint_q);
		hy12   = CMP_W'(cfg.hysteresis);

		pump_n    = pump_q;
		valve_n   = valve_q;
		sp_n      = setpoint_q;
		setting_n = setting_q;
		cnt_n     = cnt_q;

		if (p12 > sp12)
			valve_n = 1'b0;
		if ((p12 > sp12 + hy12) && (setpoint_q < cfg.pump_cutoff))
			pump_n = 1'b1;
		if (p12 < sp12)
			pump_n = 1'b0;
		if (p12 + hy12 < sp12)
			valve_n = 1'b1;

		if (res.btn.raise) begin
			setting_n = 1'b1;
			if (setpoint_q < cfg.setpoint_ceiling)
				sp_n = setpoint_q + 1'b1;
			if (cnt_q < cfg.fast_repeat_after)
				cnt_n = cnt_q + 1'b1;
		end else if (res.btn.lower) begin
			setting_n = 1'b1;
			if (setpoint_q != '0)
				sp_n = setpoint_q - 1'b1;
			if (cnt_q < cfg.fast_repeat_after)
				cnt_n = cnt_q + 1'b1;
		end else if (res.btn.zero) begin
			sp_n = '0;
		end else if (res.btn.vent) begin
			sp_n    = cfg.preset_setpoint;
			pump_n  = 1'b0;
			valve_n = 1'b1;
		end else begin
			setting_n = 1'b0;
			cnt_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			setting_q  <= 1'b0;
			cnt_q      <= '0;
			pump_q     <= 1'b0;
			valve_q    <= 1'b0;
			ctl_s6     <= '0;
		end else if (adv) begin
			ctl_s6.valid   <= res.valid;
			ctl_s6.pump    <= pump_n;
			ctl_s6.valve   <= valve_n;
			ctl_s6.setting <= setting_n;
			ctl_s6.fast    <= (cnt_n >= cfg.fast_repeat_after);
			ctl_s6.p       <= p;
			ctl_s6.disp    <= setting_n ? P_W'(sp_n) : p;
			if (res.valid) begin
				setpoint_q <= sp_n;
				setting_q  <= setting_n;
				cnt_q      <= cnt_n;
				pump_q     <= pump_n;
				valve_q    <= valve_n;
			end
		end
	end

	assign ctl = ctl_s6;

	a_vent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.valid && res.btn.vent && !res.btn.raise && !res.btn.lower
			&& !res.btn.zero)
		|=> (!pump_q && valve_q && setpoint_q == $past(cfg.preset_setpoint)))
		else $error("vent did not stop the pump, open the valve and load the preset");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.valid && !res.btn.raise && !res.btn.lower && !res.btn.zero
			&& !res.btn.vent)
		|=> (!setting_q && cnt_q == '0))
		else $error("released buttons did not clear the setting state");

endmodule

// File: design/vphc_disp.sv
// Decimal digit extraction and seven-segment encoding with leading-zero blanking.
module vphc_disp import vphc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  ctrl_res_t ctl,
	output disp_res_t dres
);

	ctrl_res_t  c_s7, c_s8;
	logic [1:0] th_s7, th_s8;
	logic [9:0] r1_s7;
	logic [3:0] h_s8;
	logic [6:0] r2_s8;

	logic [1:0]  th;
	logic [10:0] sub1;
	logic [15:0] hprod;
	logic [3:0]  h;
	logic [13:0] tprod;
	logic [3:0]  t;
	logic [3:0]  u;
	logic        blank_h, blank_t;

	always_comb begin
		if (ctl.disp >= 11'd2000) begin
			th   = 2'd2;
			sub1 = 11'd2000;
		end else if (ctl.disp >= 11'd1000) begin
			th   = 2'd1;
			sub1 = 11'd1000;
		end else begin
			th   = 2'd0;
			sub1 = 11'd0;
		end
		hprod = 16'(r1_s7) * 16'(HUND_M);
		h     = hprod[HUND_SH +: 4];
		tprod = 14'(r2_s8) * 14'(TENS_M);
		t     = tprod[TENS_SH +: 4];
		u     = 4'(r2_s8 - 7'(t) * 7'd10);
		blank_h = (th_s8 == 2'd0) && (h_s8 == 4'd0);
		blank_t = blank_h && (t == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s7 <= '0;
			c_s8 <= '0;
		end else if (adv) begin
			c_s7 <= ctl;
			c_s8 <= c_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th_s7 <= th;
			r1_s7 <= 10'(ctl.disp - sub1);
			th_s8 <= th_s7;
			h_s8  <= h;
			r2_s8 <= 7'(r1_s7 - 10'(h) * 10'd100);
		end
	end

	assign dres.valid         = c_s8.valid;
	assign dres.pump          = c_s8.pump;
	assign dres.valve         = c_s8.valve;
	assign dres.setting       = c_s8.setting;
	assign dres.fast          = c_s8.fast;
	assign dres.p             = c_s8.p;
	assign dres.seg_units     = seg_of(u);
	assign dres.seg_tens      = blank_t ? 8'h00 : seg_of(t);
	assign dres.seg_hundreds  = blank_h ? 8'h00 : seg_of(h_s8);
	assign dres.seg_thousands = (th_s8 == 2'd0) ? 8'h00 : seg_of({2'b00, th_s8});

endmodule

// File: design/vacuum_pressure_hysteresis_controller.sv
// Top level of the vacuum pressure hysteresis controller.
// Takes one sample transfer per cycle while the pipeline is not stalled; every AVG_SAMPLES samples yield one result.
// A result is presented in the output register once the last sample of its group has passed the pipeline.
// The pipeline (input register, accumulator, three multiplier stages, control, two digit
// stages) stalls only while its last stage is full and the output register is not taken.
// Asynchronous reset clears the pipeline and sum, loads setpoint 740 and register defaults.
module vacuum_pressure_hysteresis_controller import vphc_pkg::*; #(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF,
	parameter int ADC_BITS    = ADC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	vphc_in_if.sink            in_ch,
	vphc_out_if.source         out_ch
);

	cfg_t      cfg;
	btn_t      btn;
	avg_res_t  ares;
	ctrl_res_t ctl;
	disp_res_t dres;
	logic      adv;
	logic      in_acc;
	logic      out_valid_q;
	disp_res_t out_q;

	assign adv          = !(dres.valid && out_valid_q && !out_ch.ready);
	assign in_ch.ready  = adv;
	assign in_acc       = in_ch.valid && adv;
	assign btn.raise    = in_ch.btn_raise;
	assign btn.lower    = in_ch.btn_lower;
	assign btn.zero     = in_ch.btn_zero;
	assign btn.vent     = in_ch.btn_vent;

	vphc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vphc_avg #(
		.AVG_SAMPLES (AVG_SAMPLES),
		.ADC_BITS    (ADC_BITS)
	) u_avg (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_acc        (in_acc),
		.adc_sample    (in_ch.adc_sample),
		.btn           (btn),
		.sensor_offset (cfg.sensor_offset),
		.res           (ares)
	);

	vphc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.res    (ares),
		.cfg    (cfg),
		.ctl    (ctl)
	);

	vphc_disp u_disp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl    (ctl),
		.dres   (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && dres.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dres.valid) begin
			out_q <= dres;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.pump_on        = out_q.pump;
	assign out_ch.valve_open     = out_q.valve;
	assign out_ch.setting_active = out_q.setting;
	assign out_ch.fast_repeat    = out_q.fast;
	assign out_ch.pressure_torr  = out_q.p;
	assign out_ch.seg_units      = out_q.seg_units;
	assign out_ch.seg_tens       = out_q.seg_tens;
	assign out_ch.seg_hundreds   = out_q.seg_hundreds;
	assign out_ch.seg_thousands  = out_q.seg_thousands;

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled while the output register is empty");

endmodule

// File: verif/tb_vacuum_pressure_hysteresis_controller.sv
// Self-checking testbench for the vacuum pressure hysteresis controller.
`timescale 1ns / 1ps

module tb_vacuum_pressure_hysteresis_controller;
	import vphc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_CAP     = 30;

	localparam logic [2:0] REG_UNUSED_A = 3'd6;
	localparam logic [2:0] REG_UNUSED_B = 3'd7;

	localparam logic [7:0] SEG_PATTERN [10] = '{
		8'hfa, 8'h82, 8'hb9, 8'hab, 8'hc3, 8'h6b, 8'h7b, 8'ha2, 8'hfb, 8'heb
	};

	localparam btn_t BTN_NONE  = 4'b0000;
	localparam btn_t BTN_RAISE = 4'b1000;
	localparam btn_t BTN_LOWER = 4'b0100;
	localparam btn_t BTN_ZERO  = 4'b0010;
	localparam btn_t BTN_VENT  = 4'b0001;

	typedef struct packed {
		logic           pump;
		logic           valve;
		logic           setting;
		logic           fast;
		logic [P_W-1:0] torr;
		logic [7:0]     units;
		logic [7:0]     tens;
		logic [7:0]     hundreds;
		logic [7:0]     thousands;
	} panel_t;

	typedef enum logic [1:0] {SET_RESET, SET_LOW, SET_HIGH} cfg_sel_t;
	typedef enum logic [2:0] {HOLD_NONE, HOLD_RAISE, HOLD_LOWER, HOLD_ZERO, HOLD_VENT} hold_kind_t;

	typedef struct packed {
		cfg_sel_t            cfg_sel;
		logic [ADC_IN_W-1:0] level;
		btn_t                btn;
		logic                hand_checked;
		panel_t              want;
	} group_row_t;

	typedef struct {
		int unsigned     acc;
		int unsigned     count;
		logic [SP_W-1:0] setpoint;
		logic            setting;
		logic [CNT_W-1:0] repeats;
		logic            pump;
		logic            valve;
	} ctl_state_t;

	localparam panel_t P_FLOOR = '{1'b0, 1'b1, 1'b0, 1'b0, 11'd0,
		8'hfa, 8'h00, 8'h00, 8'h00};
	localparam panel_t P_TOP = '{1'b0, 1'b0, 1'b0, 1'b0, 11'd1209,
		8'heb, 8'hfa, 8'hb9, 8'h82};

	localparam group_row_t DIRECTED_GROUPS [21] = '{
		'{SET_RESET, 10'd0,    BTN_NONE,              1'b1, P_FLOOR},
		'{SET_RESET, 10'd1023, BTN_NONE,              1'b1, P_TOP},
		'{SET_RESET, 10'd700,  BTN_RAISE,             1'b0, '0},
		'{SET_RESET, 10'd700,  BTN_RAISE | BTN_LOWER, 1'b0, '0},
		'{SET_RESET, 10'd300,  BTN_LOWER,             1'b0, '0},
		'{SET_RESET, 10'd300,  BTN_ZERO | BTN_VENT,   1'b0, '0},
		'{SET_RESET, 10'd300,  BTN_LOWER,             1'b0, '0},
		'{SET_RESET, 10'd400,  BTN_NONE,              1'b0, '0},
		'{SET_RESET, 10'd100,  BTN_NONE,              1'b0, '0},
		'{SET_RESET, 10'd600,  BTN_VENT,              1'b0, '0},
		'{SET_RESET, 10'd650,  BTN_NONE,              1'b0, '0},
		'{SET_RESET, 10'd705,  BTN_NONE,              1'b0, '0},
		'{SET_LOW,   10'd1023, BTN_NONE,              1'b0, '0},
		'{SET_LOW,   10'd500,  BTN_RAISE,             1'b0, '0},
		'{SET_LOW,   10'd0,    BTN_VENT,              1'b0, '0},
		'{SET_LOW,   10'd1023, BTN_NONE,              1'b0, '0},
		'{SET_HIGH,  10'd1023, BTN_RAISE,             1'b0, '0},
		'{SET_HIGH,  10'd1022, BTN_RAISE,             1'b0, '0},
		'{SET_HIGH,  10'd0,    BTN_LOWER,             1'b0, '0},
		'{SET_HIGH,  10'd1023, BTN_VENT,              1'b0, '0},
		'{SET_HIGH,  10'd512,  BTN_NONE,              1'b0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	vphc_in_if  in_ch();
	vphc_out_if out_ch();

	vacuum_pressure_hysteresis_controller uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	cfg_t        cfg;
	ctl_state_t  ctl;
	panel_t      expected_panels [$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned burst_left;
	hold_kind_t  hold_kind;
	int unsigned hold_left;
	int unsigned rx_count;
	int unsigned rx_mode;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int seen, input int want);
		if (seen != want)
			report($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, want));
	endtask

	function automatic logic [PDATA_W-1:0] reg_value(input logic [2:0] idx);
		case (idx)
			REG_HYSTERESIS:  return PDATA_W'(cfg.hysteresis);
			REG_CEILING:     return PDATA_W'(cfg.setpoint_ceiling);
			REG_PRESET:      return PDATA_W'(cfg.preset_setpoint);
			REG_PUMP_CUTOFF: return PDATA_W'(cfg.pump_cutoff);
			REG_OFFSET:      return PDATA_W'(cfg.sensor_offset);
			REG_FAST_AFTER:  return PDATA_W'(cfg.fast_repeat_after);
			default:         return '0;
		endcase
	endfunction

	// Accumulates one sample; on the last sample of a group it runs the
	// hysteresis control and the buttons and returns the panel readout.
	function automatic bit advance_controller(input logic [ADC_IN_W-1:0] sample,
		input btn_t b, output panel_t r);
		int avg;
		int pr;
		int sp;
		int hy;
		int dv;
		int dig [4];
		logic [7:0] seg [4];
		bit lead;
		r = '0;
		ctl.acc += int'(sample) & ((1 << ADC_BITS_DEF) - 1);
		ctl.count++;
		if (ctl.count < AVG_SAMPLES_DEF)
			return 1'b0;
		avg = int'(ctl.acc / AVG_SAMPLES_DEF);
		ctl.acc = 0;
		ctl.count = 0;
		if (avg < int'(cfg.sensor_offset))
			pr = 0;
		else
			pr = (avg - int'(cfg.sensor_offset)) * 147 / 100;
		if (pr > 2047)
			pr = 2047;
		sp = int'(ctl.setpoint);
		hy = int'(cfg.hysteresis);
		if (pr > sp)
			ctl.valve = 1'b0;
		if (pr > sp + hy && ctl.setpoint < cfg.pump_cutoff)
			ctl.pump = 1'b1;
		if (pr < sp)
			ctl.pump = 1'b0;
		if (pr < sp - hy)
			ctl.valve = 1'b1;
		if (b.raise) begin
			ctl.setting = 1'b1;
			if (ctl.setpoint < cfg.setpoint_ceiling)
				ctl.setpoint++;
			if (ctl.repeats < cfg.fast_repeat_after)
				ctl.repeats++;
		end else if (b.lower) begin
			ctl.setting = 1'b1;
			if (ctl.setpoint != '0)
				ctl.setpoint--;
			if (ctl.repeats < cfg.fast_repeat_after)
				ctl.repeats++;
		end else if (b.zero) begin
			ctl.setpoint = '0;
		end else if (b.vent) begin
			ctl.setpoint = cfg.preset_setpoint;
			ctl.pump = 1'b0;
			ctl.valve = 1'b1;
		end else begin
			ctl.setting = 1'b0;
			ctl.repeats = '0;
		end
		r.pump = ctl.pump;
		r.valve = ctl.valve;
		r.setting = ctl.setting;
		r.fast = (ctl.repeats >= cfg.fast_repeat_after);
		r.torr = pr[P_W-1:0];
		dv = (ctl.setting ? int'(ctl.setpoint) : pr) % 10000;
		for (int i = 0; i < 4; i++) begin
			dig[i] = dv % 10;
			dv /= 10;
		end
		lead = 1'b1;
		for (int i = 3; i >= 0; i--) begin
			if (lead && i > 0 && dig[i] == 0) begin
				seg[i] = 8'h00;
			end else begin
				lead = 1'b0;
				seg[i] = SEG_PATTERN[dig[i]];
			end
		end
		r.units = seg[0];
		r.tens = seg[1];
		r.hundreds = seg[2];
		r.thousands = seg[3];
		return 1'b1;
	endfunction

	function automatic int clamp_adc(input int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	function automatic int pick_value(input int lo, input int hi);
		int unsigned r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return int'($urandom_range(lo, hi));
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HYSTERESIS:  cfg.hysteresis = data[HY_W-1:0];
			REG_CEILING:     cfg.setpoint_ceiling = data[SP_W-1:0];
			REG_PRESET:      cfg.preset_setpoint = data[SP_W-1:0];
			REG_PUMP_CUTOFF: cfg.pump_cutoff = data[SP_W-1:0];
			REG_OFFSET:      cfg.sensor_offset = data[SP_W-1:0];
			REG_FAST_AFTER:  cfg.fast_repeat_after = data[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_all_regs();
		for (int i = REG_HYSTERESIS; i <= REG_FAST_AFTER; i++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(i), 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== reg_value(3'(i)))
				report($sformatf("register %0d reads 0x%0h, expected 0x%0h", i, prdata,
					reg_value(3'(i))));
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic load_set(input cfg_sel_t sel);
		case (sel)
			SET_LOW: begin
				reg_write(REG_HYSTERESIS, 32'd0);
				reg_write(REG_CEILING, 32'd0);
				reg_write(REG_PRESET, 32'd1023);
				reg_write(REG_PUMP_CUTOFF, 32'd1023);
				reg_write(REG_OFFSET, 32'd0);
				reg_write(REG_FAST_AFTER, 32'd0);
			end
			SET_HIGH: begin
				reg_write(REG_HYSTERESIS, 32'hffff_ff80 | 32'd100);
				reg_write(REG_CEILING, 32'h0000_fc00 | 32'd1023);
				reg_write(REG_PRESET, 32'd0);
				reg_write(REG_PUMP_CUTOFF, 32'd0);
				reg_write(REG_OFFSET, 32'd1023);
				reg_write(REG_FAST_AFTER, 32'hffff_fff0 | 32'd15);
				reg_write(REG_UNUSED_A, '1);
				reg_write(REG_UNUSED_B, 32'h0000_0155);
			end
			default: ;
		endcase
		check_all_regs();
	endtask

	task automatic randomize_registers();
		reg_write(REG_HYSTERESIS, ($urandom << HY_W) | 32'(pick_value(0, 100)));
		reg_write(REG_CEILING, ($urandom << SP_W) | 32'(pick_value(0, 1023)));
		reg_write(REG_PRESET, ($urandom << SP_W) | 32'(pick_value(0, 1023)));
		reg_write(REG_PUMP_CUTOFF, ($urandom << SP_W) | 32'(pick_value(0, 1023)));
		reg_write(REG_OFFSET, ($urandom << SP_W) | 32'(pick_value(0, 1023)));
		reg_write(REG_FAST_AFTER, ($urandom << CNT_W) | 32'(pick_value(0, 15)));
		check_all_regs();
	endtask

	task automatic push_sample(input logic [ADC_IN_W-1:0] sample, input btn_t b,
		output bit got, output panel_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 256)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.adc_sample <= sample;
		in_ch.btn_raise <= b.raise;
		in_ch.btn_lower <= b.lower;
		in_ch.btn_zero <= b.zero;
		in_ch.btn_vent <= b.vent;
		do @(posedge clk); while (!in_ch.ready);
		got = advance_controller(sample, b, r);
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_panels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_group();
		int unsigned mode;
		int center;
		int spread;
		int target;
		int s;
		btn_t b;
		bit got;
		panel_t r;
		if (hold_left == 0) begin
			mode = $urandom_range(0, 99);
			if (mode < 35)
				hold_kind = HOLD_RAISE;
			else if (mode < 60)
				hold_kind = HOLD_LOWER;
			else if (mode < 68)
				hold_kind = HOLD_ZERO;
			else if (mode < 76)
				hold_kind = HOLD_VENT;
			else
				hold_kind = HOLD_NONE;
			hold_left = (hold_kind == HOLD_RAISE || hold_kind == HOLD_LOWER)
				? $urandom_range(1, 18) : $urandom_range(1, 3);
		end
		hold_left--;
		mode = $urandom_range(0, 19);
		spread = int'(cfg.hysteresis) + 6;
		target = int'(ctl.setpoint) + int'($urandom_range(0, 2 * spread)) - spread;
		if (mode < 3)
			center = 0;
		else if (mode < 6)
			center = ($urandom_range(0, 1) == 1) ? 1023 : 0;
		else if (mode < 10)
			center = int'($urandom_range(0, 1023));
		else if (target <= 0)
			center = int'(cfg.sensor_offset) - int'($urandom_range(0, 20));
		else
			center = int'(cfg.sensor_offset) + (target * 100 + 146) / 147;
		center = clamp_adc(center);
		for (int k = 0; k < AVG_SAMPLES_DEF; k++) begin
			if (mode < 3)
				s = int'($urandom_range(0, 1023));
			else if (mode < 6)
				s = center;
			else
				s = clamp_adc(center + int'($urandom_range(0, 6)) - 3);
			b = btn_t'($urandom);
			if (k == AVG_SAMPLES_DEF - 1) begin
				case (hold_kind)
					HOLD_RAISE: b.raise = 1'b1;
					HOLD_LOWER: begin
						b.raise = 1'b0;
						b.lower = 1'b1;
					end
					HOLD_ZERO: begin
						b.raise = 1'b0;
						b.lower = 1'b0;
						b.zero = 1'b1;
					end
					HOLD_VENT: b = BTN_VENT;
					default: b = BTN_NONE;
				endcase
			end
			push_sample(ADC_IN_W'(s), b, got, r);
			if (got)
				expected_panels.push_back(r);
		end
	endtask

	always @(negedge clk) begin
		rx_count++;
		if (rx_count % 128 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 3) != 0);
			default: out_ch.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	always @(posedge clk) begin : result_monitor
		panel_t w;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_panels.size() == 0) begin
				report("result transfer with no result expected");
			end else begin
				w = expected_panels.pop_front();
				check_field("pump_on", int'(out_ch.pump_on), int'(w.pump));
				check_field("valve_open", int'(out_ch.valve_open), int'(w.valve));
				check_field("setting_active", int'(out_ch.setting_active), int'(w.setting));
				check_field("fast_repeat", int'(out_ch.fast_repeat), int'(w.fast));
				check_field("pressure_torr", int'(out_ch.pressure_torr), int'(w.torr));
				check_field("seg_units", int'(out_ch.seg_units), int'(w.units));
				check_field("seg_tens", int'(out_ch.seg_tens), int'(w.tens));
				check_field("seg_hundreds", int'(out_ch.seg_hundreds), int'(w.hundreds));
				check_field("seg_thousands", int'(out_ch.seg_thousands), int'(w.thousands));
			end
		end
	end

	initial begin
		cfg_sel_t cur_sel;
		group_row_t row;
		bit got;
		panel_t r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.adc_sample = '0;
		in_ch.btn_raise = 1'b0;
		in_ch.btn_lower = 1'b0;
		in_ch.btn_zero = 1'b0;
		in_ch.btn_vent = 1'b0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		hold_kind = HOLD_NONE;
		hold_left = 0;
		rx_count = 0;
		rx_mode = 0;
		cfg.hysteresis = HYSTERESIS_RST;
		cfg.setpoint_ceiling = CEILING_RST;
		cfg.preset_setpoint = PRESET_RST;
		cfg.pump_cutoff = CUTOFF_RST;
		cfg.sensor_offset = OFFSET_RST;
		cfg.fast_repeat_after = FAST_AFTER_RST;
		ctl.acc = 0;
		ctl.count = 0;
		ctl.setpoint = SETPOINT_RST;
		ctl.setting = 1'b0;
		ctl.repeats = '0;
		ctl.pump = 1'b0;
		ctl.valve = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_all_regs();

		cur_sel = SET_RESET;
		foreach (DIRECTED_GROUPS[i]) begin
			row = DIRECTED_GROUPS[i];
			if (row.cfg_sel != cur_sel) begin
				settle_block();
				load_set(row.cfg_sel);
				cur_sel = row.cfg_sel;
			end
			for (int k = 0; k < AVG_SAMPLES_DEF; k++) begin
				push_sample(row.level, (k == AVG_SAMPLES_DEF - 1) ? row.btn : btn_t'($urandom),
					got, r);
				if (got)
					expected_panels.push_back(row.hand_checked ? row.want : r);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			settle_block();
			randomize_registers();
			random_group();
		end

		settle_block();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/vphc_pkg.sv
design/vphc_in_if.sv
design/vphc_out_if.sv
design/vphc_cfg.sv
design/vphc_avg.sv
design/vphc_ctrl.sv
design/vphc_disp.sv
design/vacuum_pressure_hysteresis_controller.sv
verif/tb_vacuum_pressure_hysteresis_controller.sv
